// ===== rtl/lssbr_pkg.sv =====
// shared types and constants of the long-start serial byte receiver
package lssbr_pkg;

    // width of the bit period register and of the tick counter
    localparam int PERIOD_W = 16;
    localparam int TICK_W   = 17;

    // bit period and start threshold after reset
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
    localparam logic [TICK_W-1:0]   THRESH_RESET = 17'd166;

    // floor(x/3) for x below 2**21 as (x * ceil(2**21/3)) >> 21
    localparam int              DIV3_W     = 20;
    localparam logic [DIV3_W-1:0] DIV3_RECIP = 20'd699051;
    localparam int              DIV3_SHIFT = 21;

    // timing values that the framer works with
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [TICK_W-1:0]   threshold;
    } lssbr_cfg_t;

    // framer phases
    typedef enum logic [3:0] {
        ST_WAIT_LOW  = 4'b0001,
        ST_WAIT_HIGH = 4'b0010,
        ST_MEASURE   = 4'b0100,
        ST_SAMPLE    = 4'b1000
    } lssbr_state_t;

endpackage

// ===== rtl/lssbr_cfg.sv =====
// bit period register and start-mark threshold
module lssbr_cfg
    import lssbr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    output lssbr_cfg_t          cfg
);

    logic [PERIOD_W-1:0]          period_eff;
    logic [PERIOD_W+2:0]          times_five;
    logic [PERIOD_W+DIV3_W+2:0]   product;
    logic [PERIOD_W-1:0]          period_reg;
    logic [TICK_W-1:0]            thresh_reg;

    // a zero period behaves as one tick
    assign period_eff = (cfg_wdata == '0) ? {{(PERIOD_W-1){1'b0}}, 1'b1} : cfg_wdata;

    // five times the period, then divide by three through the reciprocal
    assign times_five = {1'b0, period_eff, 2'b00} + {3'b000, period_eff};
    assign product    = {{DIV3_W{1'b0}}, times_five} * {{(PERIOD_W+3){1'b0}}, DIV3_RECIP};

    // registers updated on each write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            period_reg <= period_eff;
            thresh_reg <= product[DIV3_SHIFT+TICK_W-1:DIV3_SHIFT];
        end
    end

    assign cfg.period    = period_reg;
    assign cfg.threshold = thresh_reg;

endmodule

// ===== rtl/lssbr_in_stage.sv =====
// input register for the sampled line level
module lssbr_in_stage
    import lssbr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic in_level,
    input  logic take,
    output logic level_valid,
    output logic level
);

    logic valid_reg;
    logic level_reg;

    // room when empty or when the held tick moves on this cycle
    assign in_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload follows each input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            level_reg <= in_level;
        end
    end

    assign level_valid = valid_reg;
    assign level       = level_reg;

endmodule

// ===== rtl/lssbr_framer.sv =====
// framing state machine, bit assembly and result register
module lssbr_framer
    import lssbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lssbr_cfg_t cfg,
    input  logic       level_valid,
    input  logic       level,
    output logic       take,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte
);

    lssbr_state_t      state_reg, state_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [2:0]        bit_reg, bit_next;
    logic [7:0]        shift_reg, shift_next;
    logic              valid_reg, valid_next;
    logic [7:0]        byte_reg, byte_next;
    logic [TICK_W-1:0] tick_inc;
    logic [7:0]        with_bit;
    logic              emit;

    // a tick is processed when the result register is free or drains now
    assign take = level_valid && (!valid_reg || out_ready);

    assign tick_inc = tick_reg + {{(TICK_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        with_bit          = shift_reg;
        with_bit[bit_reg] = shift_reg[bit_reg] | level;
    end

    // next phase, counters and byte under assembly
    always_comb
    begin
        state_next = state_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        emit       = 1'b0;
        if (take)
        begin
            case (state_reg)
                ST_WAIT_LOW:
                begin
                    if (!level)
                    begin
                        state_next = ST_WAIT_HIGH;
                    end
                end
                ST_WAIT_HIGH:
                begin
                    if (level)
                    begin
                        state_next = ST_MEASURE;
                        tick_next  = '0;
                    end
                end
                ST_MEASURE:
                begin
                    if (!level)
                    begin
                        state_next = ST_WAIT_HIGH;
                        tick_next  = '0;
                    end
                    else if (tick_inc >= cfg.threshold)
                    begin
                        state_next = ST_SAMPLE;
                        tick_next  = '0;
                        bit_next   = '0;
                        shift_next = '0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                ST_SAMPLE:
                begin
                    if (tick_inc < {1'b0, cfg.period})
                    begin
                        tick_next = tick_inc;
                    end
                    else
                    begin
                        tick_next = '0;
                        if (bit_reg == 3'd7)
                        begin
                            emit       = 1'b1;
                            bit_next   = '0;
                            shift_next = '0;
                            state_next = ST_WAIT_LOW;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 3'd1;
                            shift_next = with_bit;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_WAIT_LOW;
                end
            endcase
        end
    end

    // result register, held while the receiver stalls
    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            byte_next  = with_bit;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT_LOW;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;

endmodule

// ===== rtl/long_start_serial_byte_receiver.sv =====
// top level of the long-start serial byte receiver
//
// Recovers bytes from a single-wire link sampled once per tick. Each slave
// stream transfer carries one line level in s_axis_tdata[0]; each master
// stream transfer carries one received byte, first bit on the line in bit 0.
// A start mark is a high pulse of more than floor(5*bit_period/3) ticks; the
// line is then sampled every bit_period ticks, eight times.
// bit_period is written through cfg_we/cfg_wdata (reset 100, zero acts as
// one); the start threshold is registered at the write.
// Throughput: one tick per cycle while no result waits on m_axis_tready.
// A byte becomes valid at the edge at which the tick that completes it leaves
// the input register; the byte is then held in the result register.
// Reset clears the phase, counters and both valid flags; the block then
// waits for the line to go low.
// While a result waits on m_axis_tready the framer holds; at most one more tick
// is taken into the input register, then s_axis_tready drops until the result
// is transferred.
module long_start_serial_byte_receiver
    import lssbr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [0] line_level, [7:1] zero
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] data_byte
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_wdata
);

    lssbr_cfg_t cfg;
    logic       take;
    logic       level_valid;
    logic       level;

    // bit period and threshold
    lssbr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register
    lssbr_in_stage u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_level    (s_axis_tdata[0]),
        .take        (take),
        .level_valid (level_valid),
        .level       (level)
    );

    // framing and result register
    lssbr_framer u_framer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .level_valid (level_valid),
        .level       (level),
        .take        (take),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata)
    );

endmodule

// ===== rtl/lssbr_checker.sv =====
// port-level checks of the receiver and their binding
module lssbr_checker
    import lssbr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [7:0]          m_axis_tdata
);

    // a stalled result holds its byte
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // bytes are many ticks apart, so a transfer is never followed by a new result
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result right after a transfer");

    // input side is open whenever no result is pending
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // reset leaves the result register empty
    a_rst_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind long_start_serial_byte_receiver lssbr_checker u_lssbr_checker (.*);
